### sv/btli_pkg.sv
// Shared types and constants for the blade station table interpolator.
// Used by btli_div, btli_blend and blade_table_linear_interp; no dependencies.
package btli_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Quotient bits of the weight: one integer bit and sixteen fraction bits.
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned W_W       = 17;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         entry_index;
    logic [15:0]        radius_value;
    logic signed [15:0] twist_value;
    logic [15:0]        chord_value;
  } in_t;

  typedef struct packed {
    logic signed [15:0] twist_out;
    logic [15:0]        chord_out;
    logic [5:0]         lower_index;
    logic [5:0]         upper_index;
    logic [15:0]        fraction;
  } out_t;

  typedef struct packed {
    logic [15:0] radius;
    logic [15:0] twist;
    logic [15:0] chord;
  } entry_t;

  typedef enum logic {
    TAG_TWIST = 1'b0,
    TAG_CHORD = 1'b1
  } tag_e;

  typedef struct packed {
    logic valid;
    tag_e tag;
  } blend_ctl_t;

endpackage

### sv/btli_div.sv
// Iterative restoring divider producing the 17-bit Q1.16 interpolation weight.
// Depends on btli_pkg; one quotient bit per cycle, dividend must not exceed divisor.
module btli_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [15:0]                dx_i,
  input  logic [15:0]                dr_i,
  output logic                       done_o,
  output logic [btli_pkg::W_W-1:0]   quot_o
);

  logic [16:0]                     rem_q, rem_d;
  logic [15:0]                     dr_q;
  logic [btli_pkg::W_W-1:0]        quot_q, quot_d;
  logic [btli_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic                            done_q;
  logic                            ge;
  logic [16:0]                     sub;

  always_comb begin
    ge     = rem_q >= {1'b0, dr_q};
    sub    = ge ? (rem_q - {1'b0, dr_q}) : rem_q;
    rem_d  = {sub[15:0], 1'b0};
    quot_d = {quot_q[btli_pkg::W_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= btli_pkg::DIV_CNT_W'(btli_pkg::DIV_STEPS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - btli_pkg::DIV_CNT_W'(1);
        if (cnt_q == btli_pkg::DIV_CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, dx_i};
      dr_q   <= dr_i;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### sv/btli_blend.sv
// Shared three-stage rounded linear blend: a + round(w * (b - a) / 65536).
// Depends on btli_pkg; accepts one operand set per cycle, result taken from the third register stage.
module btli_blend (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  btli_pkg::blend_ctl_t      ctl_i,
  input  logic signed [16:0]        a_i,
  input  logic signed [16:0]        b_i,
  input  logic [btli_pkg::W_W-1:0]  w_i,
  output btli_pkg::blend_ctl_t      ctl_o,
  output logic [15:0]               res_o
);

  btli_pkg::blend_ctl_t      ctl1_q, ctl2_q, ctl3_q;
  logic signed [16:0]        a1_q, a2_q;
  logic signed [17:0]        diff1_q;
  logic [btli_pkg::W_W-1:0]  w1_q;
  logic signed [35:0]        prod_q;
  logic signed [35:0]        rnd;
  logic signed [19:0]        sum;
  logic [15:0]               res_q;

  always_comb begin
    // Floor of (p + half) / 2^16 is round half up.
    rnd = (prod_q + 36'sd32768) >>> 16;
    sum = {{3{a2_q[16]}}, a2_q} + rnd[19:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q    <= a_i;
    w1_q    <= w_i;
    diff1_q <= {b_i[16], b_i} - {a_i[16], a_i};
    a2_q    <= a1_q;
    prod_q  <= $signed({1'b0, w1_q}) * diff1_q;
    res_q   <= sum[15:0];
  end

  assign ctl_o = ctl3_q;
  assign res_o = res_q;

endmodule

### sv/blade_table_linear_interp.sv
// A query scans one station per cycle (k stations examined, k no more than the stations in use),
// then runs the 17-step divider and the shared blend pipeline; a query clamped to the first or
// last station skips the divider. A load is written on acceptance and gives no result.
// Throughput: one query at a time, busy high from acceptance until the result strobe.
// Reset: asynchronous active low; entry_count returns to 1, table contents stay undefined.
// The result is shown for one cycle on done_o; the receiver cannot stall it.
module blade_table_linear_interp #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  btli_pkg::in_t   req_i,
  output logic            done_o,
  output btli_pkg::out_t  res_o,
  input  logic            cfg_we_i,
  input  logic [6:0]      cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_BT,
    ST_BC,
    ST_WAIT
  } state_e;

  state_e                     state_q;
  logic [6:0]                 entry_count_q;
  logic [IDX_W-1:0]           cur_q, last_q, lo_q, hi_q;
  logic [15:0]                q_q;
  btli_pkg::entry_t           mem_q [MAX_ENTRIES];
  btli_pkg::entry_t           rd_q, prev_q, lo_ent_q, hi_ent_q;
  logic [btli_pkg::W_W-1:0]   w_q;
  logic [15:0]                twist_q;
  logic                       done_q;
  btli_pkg::out_t             res_q;

  logic                       accept;
  logic                       wr_en;
  logic [IDX_W-1:0]           rd_addr;
  logic                       below;
  logic                       div_start;
  logic                       div_done;
  logic [btli_pkg::W_W-1:0]   div_quot;
  logic [IDX_W-1:0]           last_d;
  btli_pkg::blend_ctl_t       bl_ctl_in, bl_ctl_out;
  logic signed [16:0]         bl_a, bl_b;
  logic [15:0]                bl_res;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (req_i.cmd == btli_pkg::CMD_LOAD)
                  && (32'(req_i.entry_index) < MAX_ENTRIES);

  assign rd_addr   = (state_q == ST_SCAN) ? (cur_q + IDX_W'(1)) : '0;
  assign below     = rd_q.radius < q_q;
  assign div_start = (state_q == ST_SCAN) && !below && (cur_q != '0);

  always_comb begin
    if (entry_count_q == '0) begin
      last_d = '0;
    end else if (32'(entry_count_q) > MAX_ENTRIES) begin
      last_d = IDX_W'(MAX_ENTRIES - 1);
    end else begin
      last_d = IDX_W'(entry_count_q - 7'd1);
    end
  end

  always_comb begin
    bl_ctl_in = '0;
    bl_a      = {1'b0, lo_ent_q.chord};
    bl_b      = {1'b0, hi_ent_q.chord};
    unique case (state_q)
      ST_BT: begin
        bl_ctl_in.valid = 1'b1;
        bl_ctl_in.tag   = btli_pkg::TAG_TWIST;
        bl_a            = {lo_ent_q.twist[15], lo_ent_q.twist};
        bl_b            = {hi_ent_q.twist[15], hi_ent_q.twist};
      end
      ST_BC: begin
        bl_ctl_in.valid = 1'b1;
        bl_ctl_in.tag   = btli_pkg::TAG_CHORD;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[IDX_W'(req_i.entry_index)] <= {req_i.radius_value, req_i.twist_value,
                                           req_i.chord_value};
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= 7'd1;
      done_q        <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        entry_count_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (req_i.cmd == btli_pkg::CMD_QUERY)) begin
            q_q     <= req_i.radius_value;
            last_q  <= last_d;
            cur_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          w_q <= '0;
          if (below && (cur_q != last_q)) begin
            // advance to the next station; its data is already being read
            prev_q <= rd_q;
            cur_q  <= cur_q + IDX_W'(1);
          end else if (below) begin
            // query above the last radius: clamp to the last station
            lo_q     <= cur_q;
            hi_q     <= cur_q;
            lo_ent_q <= rd_q;
            hi_ent_q <= rd_q;
            state_q  <= ST_BT;
          end else if (cur_q == '0) begin
            lo_q     <= '0;
            hi_q     <= '0;
            lo_ent_q <= rd_q;
            hi_ent_q <= rd_q;
            state_q  <= ST_BT;
          end else begin
            lo_q     <= cur_q - IDX_W'(1);
            hi_q     <= cur_q;
            lo_ent_q <= prev_q;
            hi_ent_q <= rd_q;
            state_q  <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            w_q     <= div_quot;
            state_q <= ST_BT;
          end
        end
        ST_BT: begin
          state_q <= ST_BC;
        end
        ST_BC: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (bl_ctl_out.valid && (bl_ctl_out.tag == btli_pkg::TAG_TWIST)) begin
            twist_q <= bl_res;
          end
          if (bl_ctl_out.valid && (bl_ctl_out.tag == btli_pkg::TAG_CHORD)) begin
            res_q.twist_out   <= twist_q;
            res_q.chord_out   <= bl_res;
            res_q.lower_index <= 6'(lo_q);
            res_q.upper_index <= 6'(hi_q);
            res_q.fraction    <= w_q[16] ? 16'hFFFF : w_q[15:0];
            done_q            <= 1'b1;
            state_q           <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  btli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dx_i    (q_q - prev_q.radius),
    .dr_i    (rd_q.radius - prev_q.radius),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  btli_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (bl_ctl_in),
    .a_i    (bl_a),
    .b_i    (bl_b),
    .w_i    (w_q),
    .ctl_o  (bl_ctl_out),
    .res_o  (bl_res)
  );

  assign done_o = done_q;
  assign res_o  = res_q;

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_equal_idx_no_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.lower_index == res_o.upper_index) |-> res_o.fraction == 16'd0)
    else $error("nonzero fraction on a clamped result");

  a_adjacent_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.upper_index == res_o.lower_index)
               || (res_o.upper_index == 6'(res_o.lower_index + 6'd1)))
    else $error("bracketing stations are not adjacent");

  a_query_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.cmd == btli_pkg::CMD_QUERY) |=> busy)
    else $error("accepted query did not raise busy");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cur_q <= last_q))
    else $error("scan ran past the last station in use");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for blade_table_linear_interp: station loads and interpolation queries
// checked against an in-bench predictor of the station table. Depends on btli_pkg and the RTL.
module tb_top;

  localparam int HALF_PERIOD  = 10;
  localparam int MAX_STATIONS = 64;
  localparam int ITEM_TARGET  = 1550;
  localparam int IDLE_SETTLE  = 8;
  localparam int END_SETTLE   = 120;
  localparam int STALL_LIMIT  = 3000;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  btli_pkg::in_t   req_i       = '0;
  logic            done_o;
  btli_pkg::out_t  res_o;
  logic            cfg_we_i    = 1'b0;
  logic [6:0]      cfg_wdata_i = '0;

  // Predictor state: the station table and entry_count as the block should hold them.
  logic [15:0]        station_radius [MAX_STATIONS];
  logic signed [15:0] station_twist  [MAX_STATIONS];
  logic [15:0]        station_chord  [MAX_STATIONS];
  logic [6:0]         stations_in_use = 7'd1;

  // Radii as they will stand once every queued load has gone in; used to aim queries.
  logic [15:0] staged_radius [MAX_STATIONS];

  btli_pkg::in_t  cmd_backlog     [$];
  btli_pkg::out_t pending_answers [$];

  int             sender_idle_pct = 0;
  int             items_issued    = 0;
  int             items_taken     = 0;
  int             loads_taken     = 0;
  int             queries_taken   = 0;
  int             results_checked = 0;
  int             settings_used   = 0;
  int             error_count     = 0;
  int             quiet_cycles    = 0;
  btli_pkg::out_t want;

  blade_table_linear_interp #(
    .MAX_ENTRIES(MAX_STATIONS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // Rounded lerp in Q1.16 weight; floor of the biased sum gives round half up.
  function automatic longint lerp_q16(input longint a, input longint b, input longint w);
    longint acc;
    acc = a * 65536 + w * (b - a);
    return (acc + 32768) >>> 16;
  endfunction

  function automatic btli_pkg::out_t interp_station(input logic [15:0] q);
    int             n;
    int             lo;
    int             hi;
    longint         w;
    longint         dx;
    longint         dr;
    btli_pkg::out_t o;
    n = stations_in_use;
    if (n == 0) n = 1;
    if (n > MAX_STATIONS) n = MAX_STATIONS;
    w  = 0;
    lo = 0;
    hi = 0;
    if (n > 1) begin
      while (hi < n && station_radius[hi] < q) hi++;
      if (hi == n) begin
        hi = n - 1;
        lo = hi;
      end else if (hi != 0) begin
        lo = hi - 1;
        dx = q;
        dx = dx - station_radius[lo];
        dr = station_radius[hi];
        dr = dr - station_radius[lo];
        w  = (dx << 16) / dr;
      end
    end
    o.twist_out   = 16'(lerp_q16(station_twist[lo], station_twist[hi], w));
    o.chord_out   = 16'(lerp_q16(station_chord[lo], station_chord[hi], w));
    o.lower_index = 6'(lo);
    o.upper_index = 6'(hi);
    o.fraction    = (w > 65535) ? 16'hFFFF : 16'(w);
    return o;
  endfunction

  // Driver: hold a transaction until accepted, then update the predictor and offer the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      if (start && !busy) begin
        items_taken++;
        if (req_i.cmd == btli_pkg::CMD_LOAD) begin
          loads_taken++;
          station_radius[req_i.entry_index] = req_i.radius_value;
          station_twist[req_i.entry_index]  = req_i.twist_value;
          station_chord[req_i.entry_index]  = req_i.chord_value;
        end else begin
          queries_taken++;
          pending_answers.push_back(interp_station(req_i.radius_value));
        end
      end
      if (!(start && busy)) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          req_i <= cmd_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest outstanding query.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        $error("result strobe with no query outstanding");
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        results_checked++;
        if (res_o.twist_out !== want.twist_out) begin
          $error("twist_out: expected %0d, got %0d", want.twist_out, res_o.twist_out);
          error_count++;
        end
        if (res_o.chord_out !== want.chord_out) begin
          $error("chord_out: expected %0d, got %0d", want.chord_out, res_o.chord_out);
          error_count++;
        end
        if (res_o.lower_index !== want.lower_index) begin
          $error("lower_index: expected %0d, got %0d", want.lower_index, res_o.lower_index);
          error_count++;
        end
        if (res_o.upper_index !== want.upper_index) begin
          $error("upper_index: expected %0d, got %0d", want.upper_index, res_o.upper_index);
          error_count++;
        end
        if (res_o.fraction !== want.fraction) begin
          $error("fraction: expected %0d, got %0d", want.fraction, res_o.fraction);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  task automatic push_load(input int slot, input logic [15:0] rad, input logic [15:0] tw,
                           input logic [15:0] ch);
    btli_pkg::in_t item;
    item.cmd          = btli_pkg::CMD_LOAD;
    item.entry_index  = 6'(slot);
    item.radius_value = rad;
    item.twist_value  = tw;
    item.chord_value  = ch;
    staged_radius[slot] = rad;
    cmd_backlog.push_back(item);
    items_issued++;
  endtask

  task automatic push_query(input logic [15:0] q);
    btli_pkg::in_t item;
    item.cmd          = btli_pkg::CMD_QUERY;
    item.entry_index  = 6'($urandom);
    item.radius_value = q;
    item.twist_value  = 16'($urandom);
    item.chord_value  = 16'($urandom);
    cmd_backlog.push_back(item);
    items_issued++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (items_taken != items_issued || pending_answers.size() != 0 || busy);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic set_entry_count(input logic [6:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    stations_in_use = value;
    settings_used++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int          phase;
    int          n;
    int          cnt;
    int          pick;
    int          cap;
    int          acc;
    int          idx;
    logic [15:0] q;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single station at reset count, then a four-station table swept end to end.
    push_load(0, 16'h0010, 16'h8000, 16'h0000);
    push_query(16'hFFFF);
    set_entry_count(7'd4);
    push_load(1, 16'h0100, 16'h7FFF, 16'hFFFF);
    push_load(2, 16'h8000, 16'h0000, 16'h1234);
    push_load(3, 16'hFFF0, 16'hFFFF, 16'h0000);
    push_load(63, 16'hFFFF, 16'h7FFF, 16'hFFFF);
    push_query(16'h0000);  // below first station
    push_query(16'h0010);  // on first station
    push_query(16'h0011);
    push_query(16'h0080);
    push_query(16'h0100);  // on an upper station: full weight, fraction saturates
    push_query(16'h4000);
    push_query(16'h8001);
    push_query(16'hFFF0);  // on last station
    push_query(16'hFFFF);  // above last station

    // Write every slot once so no query can touch an unloaded station.
    set_entry_count(7'd64);
    cap = 65535 / MAX_STATIONS;
    acc = $urandom_range(0, cap);
    for (int i = 0; i < MAX_STATIONS; i++) begin
      push_load(i, 16'(acc), 16'($urandom), 16'($urandom));
      acc += $urandom_range(0, cap);
    end

    phase = 0;
    while (items_issued < ITEM_TARGET) begin
      case (phase)
        0: cnt = 0;
        1: cnt = 127;
        2: cnt = 64;
        3: cnt = 1;
        default: begin
          pick = $urandom_range(99);
          if (pick < 60) cnt = $urandom_range(2, 12);
          else if (pick < 75) cnt = $urandom_range(13, 40);
          else if (pick < 83) cnt = 64;
          else if (pick < 88) cnt = $urandom_range(65, 127);
          else if (pick < 94) cnt = 1;
          else cnt = 0;
        end
      endcase
      set_entry_count(7'(cnt));
      case (phase % 4)
        1: sender_idle_pct = 46;
        3: sender_idle_pct = 19;
        default: sender_idle_pct = 0;
      endcase
      n = (cnt == 0) ? 1 : (cnt > MAX_STATIONS) ? MAX_STATIONS : cnt;

      pick = $urandom_range(99);
      if (pick < 75) begin
        // Ascending radii; a tight step packs stations close together and makes ties.
        cap = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : 65535 / n;
        acc = $urandom_range(0, cap);
        for (int i = 0; i < n; i++) begin
          push_load(i, 16'(acc), 16'($urandom), 16'($urandom));
          acc += $urandom_range(0, cap);
        end
      end else if (pick < 88) begin
        for (int i = 0; i < n; i++) begin
          push_load($urandom_range(0, n - 1), 16'($urandom), 16'($urandom), 16'($urandom));
        end
      end

      repeat ($urandom_range(15, 35)) begin
        if ($urandom_range(99) < 8) begin
          push_load($urandom_range(0, MAX_STATIONS - 1), 16'($urandom), 16'($urandom),
                    16'($urandom));
        end else begin
          idx = $urandom_range(0, n - 1);
          case ($urandom_range(3))
            0: q = 16'($urandom);
            1: q = 16'($urandom_range(staged_radius[0], staged_radius[n - 1]));
            2: q = staged_radius[idx];
            default: q = ($urandom_range(1) != 0) ? staged_radius[idx] + 16'd1
                                                  : staged_radius[idx] - 16'd1;
          endcase
          push_query(q);
        end
      end
      phase++;
    end

    wait_idle();
    repeat (END_SETTLE) @(posedge clk_i);
    $display("tb_top: %0d loads and %0d queries over %0d entry_count settings,",
             loads_taken, queries_taken, settings_used);
    $display("tb_top: %0d interpolation results compared, %0d mismatches",
             results_checked, error_count);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/btli_pkg.sv
sv/btli_div.sv
sv/btli_blend.sv
sv/blade_table_linear_interp.sv
verif/tb_top.sv
